@@ rtl/http_chunked_body_deframer_macros.svh @@
// Assertion macros used by the deframer top level.
// Define ASSERT_OFF to compile the assertions out.
`ifndef HTTP_CHUNKED_BODY_DEFRAMER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DEFRAMER_MACROS_SVH
`ifndef ASSERT_OFF
`define HCBD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define HCBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define HCBD_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define HCBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/hcbd_pkg.sv @@
package hcbd_pkg;

   localparam int SIZE_BITS_DEFAULT   = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int CSR_DATA_BITS       = 32;
   localparam int CSR_INDEX_BITS      = 1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_LENGTH_MODE    = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CONTENT_LENGTH = 1'd1;

   // Input word kinds.
   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_START = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] stream_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_valid;
      logic       body_end;
   } rsp_type;

   // A classified input word, as the front end hands it to the back end.
   typedef struct packed {
      logic       start;
      logic [7:0] data;
      logic       is_hex;
      logic [3:0] hex_val;
      logic       is_blank;
      logic       is_cr;
      logic       is_lf;
   } cls_type;

   typedef struct packed {
      logic        length_mode;
      logic [31:0] content_length;
   } cfg_type;

endpackage

@@ rtl/hcbd_fifo.sv @@
module hcbd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ rtl/hcbd_front.sv @@
module hcbd_front #(
   parameter int QUEUE_DEPTH = hcbd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hcbd_pkg::req_type req_data,
   output logic              full,
   input  logic              cls_pop,
   output hcbd_pkg::cls_type cls_data,
   output logic              cls_empty
);

   hcbd_pkg::cls_type cls_in;
   logic [7:0]        b;

   assign b = req_data.stream_byte;

   // Decode the byte once here so the back end sees ready-made flags beside it.
   always_comb begin
      cls_in.start    = (req_data.kind == hcbd_pkg::KIND_START);
      cls_in.data     = b;
      cls_in.is_hex   = 1'b0;
      cls_in.hex_val  = 4'd0;
      cls_in.is_blank = (b == 8'h20) || (b == 8'h09);
      cls_in.is_cr    = (b == 8'h0D);
      cls_in.is_lf    = (b == 8'h0A);
      if (b >= 8'h30 && b <= 8'h39) begin
         cls_in.is_hex  = 1'b1;
         cls_in.hex_val = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         cls_in.is_hex  = 1'b1;
         cls_in.hex_val = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         cls_in.is_hex  = 1'b1;
         cls_in.hex_val = 4'(b - 8'h37);
      end
   end

   hcbd_fifo #(
      .WIDTH ($bits(hcbd_pkg::cls_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cls_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (cls_in),
      .full    (full),
      .pop     (cls_pop),
      .rd_data (cls_data),
      .empty   (cls_empty)
   );

endmodule

@@ rtl/hcbd_back.sv @@
module hcbd_back #(
   parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  hcbd_pkg::cfg_type cfg,
   input  logic              cls_empty,
   input  hcbd_pkg::cls_type cls_data,
   output logic              cls_pop,
   input  logic              out_full,
   output logic              out_push,
   output hcbd_pkg::rsp_type out_data
);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_LEN   = 3'd1;
   localparam logic [2:0] PH_SIZE  = 3'd2;
   localparam logic [2:0] PH_DATA  = 3'd3;
   localparam logic [2:0] PH_DROP  = 3'd4;
   localparam logic [2:0] PH_FINAL = 3'd5;

   localparam logic [1:0] TRAILER_BYTES = 2'd2;

   logic [2:0]           phase_ff, phase_in;
   logic [SIZE_BITS-1:0] remaining_ff, remaining_in;
   logic                 digits_open_ff, digits_open_in;
   logic                 carriage_seen_ff, carriage_seen_in;
   logic                 leading_blank_ff, leading_blank_in;
   logic [1:0]           drop_left_ff, drop_left_in;

   logic [SIZE_BITS-1:0] rem_dec;
   logic [SIZE_BITS-1:0] rem_shift;
   logic [1:0]           drop_dec;
   logic                 work;

   assign work     = !cls_empty && !out_full;
   assign cls_pop  = work;
   assign rem_dec  = remaining_ff - 1'b1;
   assign drop_dec = drop_left_ff - 1'b1;

   // Appending a digit overflows exactly when the top nibble is already set.
   always_comb begin
      if (remaining_ff[SIZE_BITS-1 -: 4] != 4'd0) begin
         rem_shift = '1;
      end else begin
         rem_shift = {remaining_ff[SIZE_BITS-5:0], cls_data.hex_val};
      end
   end

   always_comb begin
      phase_in         = phase_ff;
      remaining_in     = remaining_ff;
      digits_open_in   = digits_open_ff;
      carriage_seen_in = carriage_seen_ff;
      leading_blank_in = leading_blank_ff;
      drop_left_in     = drop_left_ff;
      out_push         = 1'b0;
      out_data         = '0;
      if (work) begin
         if (cls_data.start) begin
            drop_left_in     = 2'd0;
            remaining_in     = '0;
            digits_open_in   = 1'b1;
            carriage_seen_in = 1'b0;
            leading_blank_in = 1'b1;
            if (cfg.length_mode) begin
               if (cfg.content_length == 32'd0) begin
                  phase_in          = PH_IDLE;
                  out_push          = 1'b1;
                  out_data.body_end = 1'b1;
               end else begin
                  remaining_in = SIZE_BITS'(cfg.content_length);
                  phase_in     = PH_LEN;
               end
            end else begin
               phase_in = PH_SIZE;
            end
         end else begin
            unique case (phase_ff)
               PH_LEN, PH_DATA: begin
                  remaining_in           = rem_dec;
                  out_push               = 1'b1;
                  out_data.payload_byte  = cls_data.data;
                  out_data.payload_valid = 1'b1;
                  if (rem_dec == '0) begin
                     if (phase_ff == PH_LEN) begin
                        phase_in          = PH_IDLE;
                        out_data.body_end = 1'b1;
                     end else begin
                        phase_in     = PH_DROP;
                        drop_left_in = TRAILER_BYTES;
                     end
                  end
               end
               PH_SIZE: begin
                  if (carriage_seen_ff && cls_data.is_lf) begin
                     carriage_seen_in = 1'b0;
                     if (remaining_ff == '0) begin
                        phase_in     = PH_FINAL;
                        drop_left_in = TRAILER_BYTES;
                     end else begin
                        phase_in     = PH_DATA;
                        drop_left_in = 2'd0;
                     end
                  end else if (carriage_seen_ff) begin
                     // The held CR was an ordinary character: it closes the digits.
                     leading_blank_in = 1'b0;
                     digits_open_in   = 1'b0;
                     carriage_seen_in = cls_data.is_cr;
                  end else if (cls_data.is_cr) begin
                     carriage_seen_in = 1'b1;
                  end else if (!(leading_blank_ff && cls_data.is_blank)) begin
                     leading_blank_in = 1'b0;
                     if (digits_open_ff) begin
                        if (cls_data.is_hex) begin
                           remaining_in = rem_shift;
                        end else begin
                           digits_open_in = 1'b0;
                        end
                     end
                  end
               end
               PH_DROP: begin
                  drop_left_in = drop_dec;
                  if (drop_dec == 2'd0) begin
                     phase_in         = PH_SIZE;
                     remaining_in     = '0;
                     digits_open_in   = 1'b1;
                     carriage_seen_in = 1'b0;
                     leading_blank_in = 1'b1;
                  end
               end
               PH_FINAL: begin
                  drop_left_in = drop_dec;
                  if (drop_dec == 2'd0) begin
                     phase_in          = PH_IDLE;
                     out_push          = 1'b1;
                     out_data.body_end = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         remaining_ff     <= '0;
         digits_open_ff   <= 1'b1;
         carriage_seen_ff <= 1'b0;
         leading_blank_ff <= 1'b1;
         drop_left_ff     <= 2'd0;
      end else begin
         phase_ff         <= phase_in;
         remaining_ff     <= remaining_in;
         digits_open_ff   <= digits_open_in;
         carriage_seen_ff <= carriage_seen_in;
         leading_blank_ff <= leading_blank_in;
         drop_left_ff     <= drop_left_in;
      end
   end

endmodule

@@ rtl/http_chunked_body_deframer.sv @@
// HTTP/1.1 body deframer. Connection bytes enter as words on the req_ side
// (push/full); a word is either a stream byte or a start-of-body marker.
// Payload bytes leave as words on the rsp_ side (empty/pop): the oldest
// result sits on rsp_data while empty is low and is taken when pop is high.
// Framing bytes (chunk size lines, chunk trailers) make no result; the end
// of a body gives a result with body_end set.
// The csr_ port writes length_mode and content_length; write them only while idle (not enforced).
// Throughput is one word per cycle while the result queue has room. An
// accepted word is registered in the classify queue; the state machine
// moves it on and registers its result in the result queue, where it is
// on rsp_data for popping. The single state machine step per cycle sets
// the rate. If the receiver stops popping, the result queue fills, the
// state machine holds, and full rises once the classify queue is full.
// Synchronous reset empties both queues and returns the parser to idle
// with no body active; configuration registers reset to zero.
`include "http_chunked_body_deframer_macros.svh"

module http_chunked_body_deframer #(
   parameter int SIZE_BITS   = hcbd_pkg::SIZE_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = hcbd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   input  hcbd_pkg::req_type                     req_data,
   output logic                                  full,
   output logic                                  empty,
   input  logic                                  pop,
   output hcbd_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_write,
   input  logic [hcbd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [hcbd_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   hcbd_pkg::cfg_type cfg_ff, cfg_in;
   hcbd_pkg::cls_type cls_data;
   hcbd_pkg::rsp_type back_data;
   logic              cls_empty;
   logic              cls_pop;
   logic              back_push;
   logic              out_full;

   // Configuration registers; a write is registered before the back end sees it.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            hcbd_pkg::REG_LENGTH_MODE:    cfg_in.length_mode    = csr_wdata[0];
            hcbd_pkg::REG_CONTENT_LENGTH: cfg_in.content_length = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: byte classification into a short queue.
   hcbd_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .cls_pop   (cls_pop),
      .cls_data  (cls_data),
      .cls_empty (cls_empty)
   );

   // Back end: framing state machine, one classified word per cycle while the result queue has room.
   hcbd_back #(
      .SIZE_BITS (SIZE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cls_empty (cls_empty),
      .cls_data  (cls_data),
      .cls_pop   (cls_pop),
      .out_full  (out_full),
      .out_push  (back_push),
      .out_data  (back_data)
   );

   // Result queue decouples the state machine from the receiver.
   hcbd_fifo #(
      .WIDTH ($bits(hcbd_pkg::rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (back_push),
      .wr_data (back_data),
      .full    (out_full),
      .pop     (pop),
      .rd_data (rsp_data),
      .empty   (empty)
   );

   // A result without a payload byte only ever marks the end of a body.
   `HCBD_ASSERT_IMP(a_bare_end, clock, reset, !empty && !rsp_data.payload_valid, rsp_data.body_end && (rsp_data.payload_byte == 8'd0), "result without payload is not a clean body end")
   // The state machine must never produce a result it cannot store.
   `HCBD_ASSERT_IMP(a_no_overflow, clock, reset, back_push, !out_full, "result pushed into a full queue")
   // A word leaves the classify queue only when the result queue has room.
   `HCBD_ASSERT_IMP(a_pop_room, clock, reset, cls_pop, !cls_empty && !out_full, "classified word consumed without room")
   // Coming out of reset, no result is waiting.
   `HCBD_ASSERT_IMP(a_reset_empty, clock, reset, $past(reset), empty, "result queue not empty after reset")

endmodule
